[rtl/viterbi_gaussian_hmm_decoder_unit_defines.svh]
// Assertion macros for the Viterbi HMM decoder.
// Used by the top level only.
`ifndef VITERBI_GAUSSIAN_HMM_DECODER_UNIT_DEFINES_SVH
`define VITERBI_GAUSSIAN_HMM_DECODER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define VGH_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication failed");
// Next-cycle implication checked on every clock edge outside reset.
`define VGH_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication failed");
`endif

[rtl/vgh_pkg.sv]
// Package for the Viterbi HMM decoder: sizes, controller states, command struct, penalty function.
// No dependencies.
`timescale 1ns / 1ps
package vgh_pkg;
    localparam int MaxStates = 32;
    localparam int MaxLen = 64;
    localparam int MetricWidth = 32;
    localparam int SW = $clog2(MaxStates);
    localparam int LW = $clog2(MaxLen);
    localparam logic [5:0] NumStatesReset = 6'd20;
    localparam logic signed [15:0] FloorReset = -16'sd24755;
    localparam logic CfgNumStates = 1'b0;
    localparam logic CfgFloor = 1'b1;
    // ceil(2**30 / 50)
    localparam logic [24:0] Recip50 = 25'd21474837;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ACS_RD, ST_ACS, ST_ACS_WB, ST_COPY,
        ST_SEL, ST_TB_RD, ST_TB_OUT, ST_TB_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic       tbl_wr;
        logic       first;
        logic       acs_init;
        logic       acs_take;
        logic       nm_wr;
        logic       bp_wr;
        logic       copy;
        logic       sel;
        logic       sel_init;
        logic       bp_take;
        logic [SW-1:0] x;
        logic [SW-1:0] p;
        logic [LW-1:0] t;
    } dp_cmd_t;

    // Emission penalty round((d*d*256)/50) for d in 0..255, by reciprocal multiply.
    function automatic logic [18:0] penalty(input logic [7:0] d);
        logic [15:0] sq;
        logic [23:0] num;
        logic [48:0] prod;
        sq = 16'(d) * 16'(d);
        num = {sq, 8'd0} + 24'd25;
        prod = 49'(num) * 49'(Recip50);
        return prod[48:30];
    endfunction
endpackage

[rtl/vgh_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vgh_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/vgh_datapath.sv]
// Datapath: transition table, metric stores, backpointers and the shared ACS unit.
// Depends on vgh_pkg and vgh_ram.
`timescale 1ns / 1ps
module vgh_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vgh_pkg::dp_cmd_t            cmd,
    input  logic [vgh_pkg::SW-1:0]      ld_from,
    input  logic [vgh_pkg::SW-1:0]      ld_to,
    input  logic signed [15:0]          ld_value,
    input  logic [7:0]                  obs,
    input  logic signed [15:0]          metric_floor,
    output logic [vgh_pkg::SW-1:0]      cur_state
);
    localparam int MW = vgh_pkg::MetricWidth;
    localparam int SW = vgh_pkg::SW;
    localparam logic signed [MW+1:0] MMin = -(MW+2)'(2) ** (MW-1);
    localparam logic signed [MW+1:0] MMax = (MW+2)'(2) ** (MW-1) - 1;

    logic signed [15:0] tbl_rd;
    logic [SW-1:0] bp_rd;
    logic signed [MW-1:0] pm_reg [vgh_pkg::MaxStates];
    logic signed [MW-1:0] nm_reg [vgh_pkg::MaxStates];
    logic signed [MW-1:0] best_reg, best_next;
    logic [SW-1:0] arg_reg, arg_next;
    logic [SW-1:0] p_d_reg;
    logic signed [MW-1:0] pm_p_reg;
    logic signed [MW-1:0] sel_best_reg;
    logic [SW-1:0] cur_reg, cur_next;
    logic [7:0] obs_dist;
    logic [18:0] pen_reg;
    logic signed [22:0] emis;
    logic signed [22:0] br_raw;
    logic signed [22:0] br;
    logic signed [MW+1:0] sum;
    logic signed [MW-1:0] v;

    vgh_ram #(.Width(16), .Depth(vgh_pkg::MaxStates * vgh_pkg::MaxStates)) u_tbl (
        .clk(clk), .we(cmd.tbl_wr), .waddr({ld_from, ld_to}), .wdata(ld_value),
        .raddr({cmd.p, cmd.x}), .rdata(tbl_rd)
    );

    vgh_ram #(.Width(SW), .Depth(vgh_pkg::MaxLen * vgh_pkg::MaxStates)) u_bp (
        .clk(clk), .we(cmd.bp_wr), .waddr({cmd.t, cmd.x}), .wdata(arg_reg),
        .raddr({cmd.t, cur_reg}), .rdata(bp_rd)
    );

    always_comb
    begin
        obs_dist = ({3'd0, cmd.x} > obs) ? 8'({3'd0, cmd.x} - obs) : 8'(obs - {3'd0, cmd.x});
        emis = -23'(pen_reg);
        br_raw = cmd.first ? emis : (23'(tbl_rd) + emis);
        br = (br_raw < 23'(metric_floor)) ? 23'(metric_floor) : br_raw;
        sum = cmd.first ? (MW+2)'(br) : ((MW+2)'(pm_p_reg) + (MW+2)'(br));
        v = (sum < MMin) ? MW'(MMin) : ((sum > MMax) ? MW'(MMax) : MW'(sum));
        best_next = best_reg;
        arg_next = arg_reg;
        if (cmd.acs_take && (cmd.acs_init || v > best_reg))
        begin
            best_next = v;
            arg_next = p_d_reg;
        end
        cur_next = cur_reg;
        if (cmd.sel && (cmd.sel_init || pm_reg[cmd.p] > sel_best_reg))
        begin
            cur_next = cmd.p;
        end
        if (cmd.bp_take)
        begin
            cur_next = bp_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        // x is stable from the read cycle on, so the penalty is ready for the ACS cycle
        pen_reg <= vgh_pkg::penalty(obs_dist);
        p_d_reg <= cmd.p;
        pm_p_reg <= pm_reg[cmd.p];
        best_reg <= best_next;
        arg_reg <= arg_next;
        if (cmd.nm_wr)
        begin
            if (cmd.first)
            begin
                pm_reg[cmd.x] <= best_reg;
            end
            else
            begin
                nm_reg[cmd.x] <= best_reg;
            end
        end
        if (cmd.copy)
        begin
            pm_reg[cmd.x] <= nm_reg[cmd.x];
        end
        if (cmd.sel && (cmd.sel_init || pm_reg[cmd.p] > sel_best_reg))
        begin
            sel_best_reg <= pm_reg[cmd.p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

    assign cur_state = cur_reg;
endmodule

[rtl/vgh_ctrl.sv]
// Controller: sequences loads, ACS sweeps, final selection and traceback.
// Depends on vgh_pkg.
`timescale 1ns / 1ps
module vgh_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    req_kind,
    input  logic                    req_last,
    input  logic [5:0]              state_cnt,
    output logic                    first_ld,
    output vgh_pkg::dp_cmd_t        cmd,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [vgh_pkg::LW-1:0]  res_pos,
    output logic                    res_last
);
    localparam int SW = vgh_pkg::SW;
    localparam int LW = vgh_pkg::LW;

    vgh_pkg::ctrl_state_t state_reg, state_next;
    logic [SW-1:0] x_reg, x_next, p_reg, p_next;
    logic [LW:0] step_reg, step_next;
    logic [LW-1:0] t_reg, t_next;
    logic last_reg, last_next;
    logic [LW-1:0] k_reg, k_next;
    logic [SW:0] n;
    logic [SW-1:0] nmax;

    always_comb
    begin
        if (state_cnt < 6'd2)
        begin
            n = (SW+1)'(2);
        end
        else if (state_cnt > 6'(vgh_pkg::MaxStates))
        begin
            n = (SW+1)'(vgh_pkg::MaxStates);
        end
        else
        begin
            n = (SW+1)'(state_cnt);
        end
        nmax = SW'(n - (SW+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vgh_pkg::ST_IDLE;
            x_reg <= '0;
            p_reg <= '0;
            step_reg <= '0;
            t_reg <= '0;
            last_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg <= x_next;
            p_reg <= p_next;
            step_reg <= step_next;
            t_reg <= t_next;
            last_reg <= last_next;
            k_reg <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        p_next = p_reg;
        step_next = step_reg;
        t_next = t_reg;
        last_next = last_reg;
        k_next = k_reg;
        req_ready = 1'b0;
        res_valid = 1'b0;
        first_ld = 1'b0;
        cmd = '0;
        cmd.x = x_reg;
        cmd.p = p_reg;
        cmd.t = t_reg;
        cmd.first = (t_reg == '0);
        res_pos = k_reg;
        res_last = (k_reg == '0);
        case (state_reg)
            vgh_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (!req_kind)
                    begin
                        first_ld = 1'b1;
                    end
                    else
                    begin
                        t_next = (step_reg >= (LW+1)'(vgh_pkg::MaxLen)) ? '0 : LW'(step_reg);
                        last_next = req_last;
                        x_next = '0;
                        p_next = '0;
                        state_next = vgh_pkg::ST_ACS_RD;
                    end
                end
            end
            vgh_pkg::ST_ACS_RD:
            begin
                // table read issued at p, data valid next cycle
                if (t_reg == '0)
                begin
                    p_next = '0;
                end
                state_next = vgh_pkg::ST_ACS;
                cmd.acs_init = 1'b1;
            end
            vgh_pkg::ST_ACS:
            begin
                cmd.p = p_reg;
                cmd.acs_take = 1'b1;
                cmd.acs_init = (p_reg == '0);
                if (t_reg == '0 || p_reg == nmax)
                begin
                    state_next = vgh_pkg::ST_ACS_WB;
                end
                else
                begin
                    p_next = p_reg + SW'(1);
                    state_next = vgh_pkg::ST_ACS_RD;
                end
            end
            vgh_pkg::ST_ACS_WB:
            begin
                cmd.nm_wr = 1'b1;
                cmd.bp_wr = (t_reg != '0);
                p_next = '0;
                if (x_reg == nmax)
                begin
                    x_next = '0;
                    state_next = (t_reg == '0) ? vgh_pkg::ST_LOAD : vgh_pkg::ST_COPY;
                end
                else
                begin
                    x_next = x_reg + SW'(1);
                    state_next = vgh_pkg::ST_ACS_RD;
                end
            end
            vgh_pkg::ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (x_reg == nmax)
                begin
                    x_next = '0;
                    state_next = vgh_pkg::ST_LOAD;
                end
                else
                begin
                    x_next = x_reg + SW'(1);
                end
            end
            vgh_pkg::ST_LOAD:
            begin
                // step bookkeeping, decide on traceback
                step_next = (LW+1)'(t_reg) + (LW+1)'(1);
                p_next = '0;
                if (last_reg || t_reg == LW'(vgh_pkg::MaxLen - 1))
                begin
                    k_next = t_reg;
                    state_next = vgh_pkg::ST_SEL;
                end
                else
                begin
                    state_next = vgh_pkg::ST_IDLE;
                end
            end
            vgh_pkg::ST_SEL:
            begin
                cmd.sel = 1'b1;
                cmd.sel_init = (p_reg == '0);
                if (p_reg == nmax)
                begin
                    state_next = vgh_pkg::ST_TB_OUT;
                end
                else
                begin
                    p_next = p_reg + SW'(1);
                end
            end
            vgh_pkg::ST_TB_OUT:
            begin
                res_valid = 1'b1;
                cmd.t = k_reg;
                if (res_ready)
                begin
                    if (k_reg == '0)
                    begin
                        step_next = '0;
                        state_next = vgh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = vgh_pkg::ST_TB_RD;
                    end
                end
            end
            vgh_pkg::ST_TB_RD:
            begin
                cmd.t = k_reg;
                cmd.bp_take = 1'b1;
                k_next = k_reg - LW'(1);
                state_next = vgh_pkg::ST_TB_WAIT;
            end
            vgh_pkg::ST_TB_WAIT:
            begin
                cmd.t = k_reg;
                state_next = vgh_pkg::ST_TB_OUT;
            end
            default:
            begin
                state_next = vgh_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/viterbi_gaussian_hmm_decoder_unit.sv]
// Viterbi HMM decoder, Gaussian emissions, log domain (Q8.8).
// Channels: s_axis carries loads and observations; m_axis carries decoded
// states last position first; cfg_* writes the state count (0) and metric_floor (1).
// A load is written straight into the transition RAM. Each observation is
// processed for the N active states by the single shared add-compare-select
// unit, reading the transition RAM once per pair. Traceback first selects
// the end state over the N active states, then reads one backpointer per result.
// Results are held while m_axis_tready is low; no input is taken until the
// traceback has finished. Reset clears the controller and step count and
// restores register defaults; table, metrics and backpointers are not cleared
// and must be written before they are read.
// Depends on vgh_pkg, vgh_ctrl, vgh_datapath, vgh_ram and the defines header.
`timescale 1ns / 1ps
`include "viterbi_gaussian_hmm_decoder_unit_defines.svh"
module viterbi_gaussian_hmm_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: from_state[4:0], to_state[9:5], trans_log[25:10],
    // observation[33:26], zeros to 39; tuser: kind; tlast: last
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: state[4:0], position[10:5], zeros to 15; tlast: last_out
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    logic [5:0] state_cnt_reg;
    logic signed [15:0] floor_reg;
    logic [7:0] obs_reg;
    logic first_ld;
    vgh_pkg::dp_cmd_t cmd;
    logic [vgh_pkg::SW-1:0] cur_state;
    logic [vgh_pkg::LW-1:0] res_pos;
    logic res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_cnt_reg <= vgh_pkg::NumStatesReset;
            floor_reg <= vgh_pkg::FloorReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == vgh_pkg::CfgNumStates)
            begin
                state_cnt_reg <= cfg_wdata[5:0];
            end
            else
            begin
                floor_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            obs_reg <= s_axis_tdata[33:26];
        end
    end

    vgh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(s_axis_tvalid), .req_ready(s_axis_tready),
        .req_kind(s_axis_tuser), .req_last(s_axis_tlast),
        .state_cnt(state_cnt_reg), .first_ld(first_ld), .cmd(cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_pos(res_pos), .res_last(res_last)
    );

    vgh_pkg::dp_cmd_t dp_cmd;
    always_comb
    begin
        dp_cmd = cmd;
        dp_cmd.tbl_wr = first_ld;
    end

    vgh_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dp_cmd),
        .ld_from(s_axis_tdata[4:0]), .ld_to(s_axis_tdata[9:5]),
        .ld_value(s_axis_tdata[25:10]), .obs(obs_reg),
        .metric_floor(floor_reg), .cur_state(cur_state)
    );

    assign m_axis_tdata = {5'd0, res_pos, cur_state};
    assign m_axis_tlast = res_last;

    `VGH_ASSERT_IMPLY(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `VGH_ASSERT_IMPLY(a_last_pos0, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[10:5] == 6'd0)
    `VGH_ASSERT_NEXT(a_load_one_cycle, clk, rst_n,
        s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready)
endmodule
